// ===== sv/ipol_pkg.sv =====
// shared types and codes for the ipv6 on-link prefix table
package ipol_pkg;

    localparam int unsigned FULL_LEN = 128;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned LIFE_W   = 32;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_EXPIRED   = 3'd6
    } status_t;

    // input op codes
    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // one table entry held by a cell
    typedef struct packed {
        logic              used;
        logic [63:0]       hi;
        logic [63:0]       lo;
        logic [LEN_W-1:0]  len;
        logic [LIFE_W-1:0] rem;
    } entry_t;

    // what a cell does this cycle
    typedef enum logic [2:0] {
        CA_HOLD,
        CA_SHR,
        CA_SHL,
        CA_LOAD,
        CA_REFRESH,
        CA_DEC
    } cell_act_t;

    // search key broadcast to every cell
    typedef struct packed {
        logic [63:0]       hi;
        logic [63:0]       lo;
        logic [LEN_W-1:0]  len;
        logic [LIFE_W-1:0] life;
    } key_t;

endpackage

// ===== sv/ipol_cell.sv =====
// one cell of the prefix chain: holds an entry, matches against the key
module ipol_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipol_pkg::cell_act_t act,
    input  ipol_pkg::key_t     key,
    input  ipol_pkg::entry_t   left_ent,
    input  ipol_pkg::entry_t   right_ent,
    output ipol_pkg::entry_t   ent,
    output logic               hit,
    output logic               expiring,
    output logic [7:0]         min_len
);
    import ipol_pkg::*;

    entry_t       ent_reg, ent_next;
    logic [127:0] mask;
    logic [7:0]   shift;

    // shorter of stored and key length, then the compare mask
    always_comb begin
        min_len = (ent_reg.len < key.len) ? ent_reg.len : key.len;
        shift   = 8'(FULL_LEN) - min_len;
        mask    = {128{1'b1}} << shift;
        if (min_len == 8'd0) begin
            mask = '0;
        end
        hit      = ent_reg.used && ((({ent_reg.hi, ent_reg.lo} ^ {key.hi, key.lo}) & mask)
                   == 128'd0);
        expiring = ent_reg.used && (ent_reg.rem == '0);
    end

    // next entry by action
    always_comb begin
        ent_next = ent_reg;
        case (act)
            CA_HOLD:    ent_next = ent_reg;
            CA_SHR:     ent_next = left_ent;
            CA_SHL:     ent_next = right_ent;
            CA_LOAD:    ent_next = '{used: 1'b1, hi: key.hi, lo: key.lo, len: key.len,
                                     rem: key.life};
            CA_REFRESH: begin
                ent_next.len = min_len;
                ent_next.rem = key.life;
            end
            CA_DEC: begin
                if (ent_reg.used && ent_reg.rem != '0) begin
                    ent_next.rem = ent_reg.rem - 1'b1;
                end
            end
            default:    ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.used <= 1'b0;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

// ===== sv/ipv6_onlink_prefix_table.sv =====
// top level: chain of prefix cells with a control sequencer
// an update or lookup item is worked in S_WORK once the output register is free, then S_IDLE takes the next
// a tick counts every entry down in S_DEC, then S_SCAN gives one result per expired entry, newest first
// one item is worked at a time; each result waits in an output register
// entries are kept packed in age order, cell 0 the newest, so the newest match is the lowest matching cell
// reset: synchronous active-low aresetn empties the table and the output
module ipv6_onlink_prefix_table #(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], addr_hi[65:2], addr_lo[129:66], plen[137:130], onlink[138], lifetime[170:139]
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], res_hi[66:3], res_lo[130:67], res_len[138:131]
    output logic [143:0] m_tdata,
    output logic         m_tlast
);
    import ipol_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_DEC, S_SCAN} state_t;
    typedef enum logic [2:0] {CM_NONE, CM_INS, CM_DROP, CM_REFRESH, CM_DEC} cmd_t;

    state_t            state_reg;
    op_t               op_reg;
    logic              onlink_reg;
    key_t              key_reg;
    logic              out_valid_reg, out_last_reg;
    status_t           out_status_reg;
    logic [63:0]       out_hi_reg, out_lo_reg;
    logic [7:0]        out_len_reg;

    entry_t            ents [ENTRIES];
    cell_act_t         acts [ENTRIES];
    logic [7:0]        mins [ENTRIES];
    logic [ENTRIES-1:0] hit_vec, exp_vec, exp_rest;
    logic              any_hit, any_exp;
    logic [IW-1:0]     hit_idx, exp_idx, sel_idx;
    entry_t            sel_ent;
    logic [7:0]        sel_min;
    logic              out_free;
    logic              out_load;
    cmd_t              cmd;
    logic [7:0]        plen_in;

    // cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        entry_t lft, rgt;
        if (g == 0) begin : g_first
            assign lft = '0;
        end else begin : g_mid
            assign lft = ents[g-1];
        end
        if (g == ENTRIES - 1) begin : g_last
            assign rgt = '0;
        end else begin : g_inner
            assign rgt = ents[g+1];
        end
        ipol_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .act       (acts[g]),
            .key       (key_reg),
            .left_ent  (lft),
            .right_ent (rgt),
            .ent       (ents[g]),
            .hit       (hit_vec[g]),
            .expiring  (exp_vec[g]),
            .min_len   (mins[g])
        );
    end

    // newest matching and newest expiring cell
    always_comb begin
        hit_idx = '0;
        exp_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_idx = IW'(i);
            if (exp_vec[i]) exp_idx = IW'(i);
        end
        any_hit  = |hit_vec;
        any_exp  = |exp_vec;
        exp_rest = exp_vec & (exp_vec - 1'b1);
        sel_idx  = (state_reg == S_SCAN) ? exp_idx : hit_idx;
        sel_ent  = ents[sel_idx];
        sel_min  = mins[sel_idx];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_WORK) || (state_reg == S_SCAN && any_exp));
    assign s_tready = (state_reg == S_IDLE);
    assign plen_in  = (s_tdata[137:130] > 8'(FULL_LEN)) ? 8'(FULL_LEN) : s_tdata[137:130];

    // table command for this cycle
    always_comb begin
        cmd = CM_NONE;
        case (state_reg)
            S_WORK: begin
                if (out_free && op_reg == OP_UPDATE && onlink_reg) begin
                    if (any_hit) begin
                        cmd = (key_reg.life == '0) ? CM_DROP : CM_REFRESH;
                    end else if (key_reg.life != '0 && !ents[ENTRIES-1].used) begin
                        cmd = CM_INS;
                    end
                end
            end
            S_DEC:  cmd = CM_DEC;
            S_SCAN: begin
                if (out_free && any_exp) cmd = CM_DROP;
            end
            default: cmd = CM_NONE;
        endcase
    end

    // per-cell actions
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            acts[i] = CA_HOLD;
            case (cmd)
                CM_INS:     acts[i] = (i == 0) ? CA_LOAD : CA_SHR;
                CM_DROP:    acts[i] = (IW'(i) >= sel_idx) ? CA_SHL : CA_HOLD;
                CM_REFRESH: acts[i] = (IW'(i) == sel_idx) ? CA_REFRESH : CA_HOLD;
                CM_DEC:     acts[i] = CA_DEC;
                default:    acts[i] = CA_HOLD;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_load || (out_valid_reg && !m_tready);
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= op_t'(s_tdata[1:0]);
                        key_reg.hi   <= s_tdata[65:2];
                        key_reg.lo   <= s_tdata[129:66];
                        onlink_reg   <= s_tdata[138];
                        key_reg.life <= s_tdata[170:139];
                        key_reg.len  <= (s_tdata[1:0] == OP_LOOKUP) ? 8'(FULL_LEN) : plen_in;
                        state_reg    <= (s_tdata[1:0] == OP_TICK) ? S_DEC : S_WORK;
                    end
                end
                S_WORK: begin
                    if (out_free) begin
                        out_last_reg   <= 1'b1;
                        out_status_reg <= ST_IGNORED;
                        out_hi_reg     <= '0;
                        out_lo_reg     <= '0;
                        out_len_reg    <= '0;
                        state_reg      <= S_IDLE;
                        if (op_reg == OP_LOOKUP) begin
                            if (any_hit) begin
                                out_status_reg <= ST_FOUND;
                                out_hi_reg     <= sel_ent.hi;
                                out_lo_reg     <= sel_ent.lo;
                                out_len_reg    <= sel_ent.len;
                            end else begin
                                out_status_reg <= ST_NOT_FOUND;
                            end
                        end else if (op_reg == OP_UPDATE && onlink_reg) begin
                            if (any_hit) begin
                                out_status_reg <= (key_reg.life == '0) ? ST_EXPIRED
                                                                       : ST_UPDATED;
                                out_hi_reg     <= sel_ent.hi;
                                out_lo_reg     <= sel_ent.lo;
                                out_len_reg    <= sel_min;
                            end else if (key_reg.life == '0) begin
                                out_status_reg <= ST_EXPIRED;
                                out_hi_reg     <= key_reg.hi;
                                out_lo_reg     <= key_reg.lo;
                                out_len_reg    <= key_reg.len;
                            end else if (ents[ENTRIES-1].used) begin
                                out_status_reg <= ST_FULL;
                            end else begin
                                out_status_reg <= ST_INSERTED;
                                out_hi_reg     <= key_reg.hi;
                                out_lo_reg     <= key_reg.lo;
                                out_len_reg    <= key_reg.len;
                            end
                        end
                    end
                end
                S_DEC: state_reg <= S_SCAN;
                S_SCAN: begin
                    if (!any_exp) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_last_reg   <= (exp_rest == '0);
                        out_status_reg <= ST_EXPIRED;
                        out_hi_reg     <= sel_ent.hi;
                        out_lo_reg     <= sel_ent.lo;
                        out_len_reg    <= sel_ent.len;
                        if (exp_rest == '0) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_lo_reg, out_hi_reg, out_status_reg};

endmodule

// ===== sv/ipol_checker.sv =====
// port-level checks for the prefix table, bound to the top level
module ipol_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         m_tlast
);
    import ipol_pkg::*;

    // a held result stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    // status code seven is never produced
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("undefined status code");

    // every result other than an expiry closes its item
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_EXPIRED |-> m_tlast)
        else $error("single result without last");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an accepted item closes the input side for the next cycle
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind ipv6_onlink_prefix_table ipol_checker u_ipol_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/ipv6_onlink_prefix_table_tb.sv =====
// testbench for the ipv6 on-link prefix table: random and directed items against a predictor
`timescale 1ns / 1ps

module ipv6_onlink_prefix_table_tb;
    import ipol_pkg::*;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [31:0] life;
        logic        onlink;
        logic [7:0]  plen;
        logic [63:0] lo;
        logic [63:0] hi;
        op_t         op;
    } req_t;

    typedef struct packed {
        logic        last;
        logic [7:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        status_t     status;
    } rsp_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tlast;

    ipv6_onlink_prefix_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor copy of the table
    logic        tbl_used [NSLOT];
    logic [63:0] tbl_hi   [NSLOT];
    logic [63:0] tbl_lo   [NSLOT];
    logic [7:0]  tbl_len  [NSLOT];
    logic [31:0] tbl_rem  [NSLOT];
    int          tbl_rank [NSLOT];

    req_t pending_items[$];
    rsp_t expected_rsps[$];
    int   mismatches;
    int   rsp_count;
    int   expire_count;
    bit   quiet_drive;
    bit   hold_sender;

    function automatic logic [127:0] prefix_mask(int len);
        logic [127:0] m;
        m = '0;
        if (len > 0) m = ~128'd0 << (128 - len);
        return m;
    endfunction

    function automatic int newest_hit(logic [63:0] hi, logic [63:0] lo, int len);
        int best;
        int l;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            l = (tbl_len[i] < len) ? tbl_len[i] : len;
            if (tbl_used[i] && ((({tbl_hi[i], tbl_lo[i]} ^ {hi, lo}) & prefix_mask(l)) == 0)
                && (best < 0 || tbl_rank[i] < tbl_rank[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void retire_slot(int s);
        tbl_used[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i] && tbl_rank[i] > tbl_rank[s]) tbl_rank[i]--;
    endfunction

    function automatic void push_rsp(status_t st, logic [63:0] hi, logic [63:0] lo,
                                     logic [7:0] len);
        rsp_t r;
        r.status = st;
        r.hi = hi;
        r.lo = lo;
        r.len = len;
        r.last = 1'b0;
        expected_rsps.push_back(r);
    endfunction

    // compute the results of one accepted item
    function automatic void predict_table(req_t q);
        int s;
        int n;
        int plen;
        int free_slot;
        n = 0;
        plen = (q.plen > 128) ? 128 : q.plen;
        case (q.op)
            OP_UPDATE: begin
                n = 1;
                if (!q.onlink) begin
                    push_rsp(ST_IGNORED, 0, 0, 0);
                end else begin
                    s = newest_hit(q.hi, q.lo, plen);
                    if (s >= 0) begin
                        if (plen < tbl_len[s]) tbl_len[s] = 8'(plen);
                        if (q.life == 0) begin
                            push_rsp(ST_EXPIRED, tbl_hi[s], tbl_lo[s], tbl_len[s]);
                            retire_slot(s);
                        end else begin
                            tbl_rem[s] = q.life;
                            push_rsp(ST_UPDATED, tbl_hi[s], tbl_lo[s], tbl_len[s]);
                        end
                    end else if (q.life == 0) begin
                        push_rsp(ST_EXPIRED, q.hi, q.lo, 8'(plen));
                    end else begin
                        free_slot = -1;
                        for (int i = NSLOT - 1; i >= 0; i--)
                            if (!tbl_used[i]) free_slot = i;
                        if (free_slot < 0) begin
                            push_rsp(ST_FULL, 0, 0, 0);
                        end else begin
                            for (int i = 0; i < NSLOT; i++)
                                if (tbl_used[i]) tbl_rank[i]++;
                            tbl_used[free_slot] = 1'b1;
                            tbl_hi[free_slot] = q.hi;
                            tbl_lo[free_slot] = q.lo;
                            tbl_len[free_slot] = 8'(plen);
                            tbl_rem[free_slot] = q.life;
                            tbl_rank[free_slot] = 0;
                            push_rsp(ST_INSERTED, q.hi, q.lo, 8'(plen));
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                n = 1;
                s = newest_hit(q.hi, q.lo, 128);
                if (s >= 0) push_rsp(ST_FOUND, tbl_hi[s], tbl_lo[s], tbl_len[s]);
                else push_rsp(ST_NOT_FOUND, 0, 0, 0);
            end
            OP_TICK: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i] && tbl_rem[i] > 0) tbl_rem[i]--;
                forever begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_used[i] && tbl_rem[i] == 0
                            && (s < 0 || tbl_rank[i] < tbl_rank[s]))
                            s = i;
                    if (s < 0 || n >= NSLOT) break;
                    push_rsp(ST_EXPIRED, tbl_hi[s], tbl_lo[s], tbl_len[s]);
                    retire_slot(s);
                    n++;
                    expire_count++;
                end
            end
            default: begin
                n = 1;
                push_rsp(ST_IGNORED, 0, 0, 0);
            end
        endcase
        if (n > 0) expected_rsps[$].last = 1'b1;
    endfunction

    // driver: feed pending items, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_table(req_t'(s_tdata[170:0]));
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && !hold_sender
                    && (quiet_drive || $urandom_range(99) >= 33)) begin
                    s_tdata  <= {5'd0, pending_items.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure and field compare
    always @(posedge aclk) begin
        rsp_t got;
        rsp_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[138:0]};
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d %h_%h len=%0d last=%b / got st=%0d %h_%h len=%0d last=%b",
                                     exp_r.status, exp_r.hi, exp_r.lo, exp_r.len, exp_r.last,
                                     got.status, got.hi, got.lo, got.len, got.last);
                    end
                end
            end
            m_tready <= quiet_drive || ($urandom_range(99) >= 33);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void add_item(op_t op, logic [63:0] hi, logic [63:0] lo,
                                     logic [7:0] plen, logic onlink, logic [31:0] life);
        req_t q;
        q.op = op;
        q.hi = hi;
        q.lo = lo;
        q.plen = plen;
        q.onlink = onlink;
        q.life = life;
        pending_items.push_back(q);
    endfunction

    // stimulus
    initial begin
        logic [63:0] base_hi [8];
        logic [63:0] base_lo [8];
        int k;
        int r;
        int plen;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        rsp_count = 0;
        expire_count = 0;
        quiet_drive = 1'b0;
        hold_sender = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_hi[i] = '0;
            tbl_lo[i] = '0;
            tbl_len[i] = '0;
            tbl_rem[i] = '0;
            tbl_rank[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ignored, insert, lookup, shrink, oversized, zero life, op 3
        add_item(OP_UPDATE, 64'h2001_0db8_0000_0000, 0, 64, 1'b0, 100);
        add_item(OP_UPDATE, 64'h2001_0db8_0000_0000, 64'h1, 64, 1'b1, 3);
        add_item(OP_LOOKUP, 64'h2001_0db8_0000_0000, 64'hdead, 0, 0, 0);
        add_item(OP_UPDATE, 64'h2001_0db8_0000_0000, 0, 48, 1'b1, 5);
        add_item(OP_UPDATE, '1, '1, 8'hff, 1'b1, 32'hffff_ffff);
        add_item(OP_LOOKUP, '1, '1, 0, 0, 0);
        add_item(OP_LOOKUP, '1, 64'hfffe, 0, 0, 0);
        add_item(OP_UPDATE, 64'h3000_0000_0000_0000, 0, 8, 1'b1, 0);
        add_item(OP_UPDATE, '1, '1, 128, 1'b1, 0);
        add_item(OP_NONE, '1, '1, '1, 1'b1, '1);
        add_item(OP_UPDATE, 0, 0, 0, 1'b1, 2);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_LOOKUP, 0, 0, 0, 0, 0);
        // fill the table, then overflow, then zero life on full table
        for (int i = 0; i < 17; i++)
            add_item(OP_UPDATE, {8'h40 + i[7:0], 56'd0}, 0, 8, 1'b1, 32'(1 + i % 3));
        add_item(OP_UPDATE, 64'h7700_0000_0000_0000, 0, 16, 1'b1, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);

        // pause until all expected results have been received
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (expected_rsps.size() == 0 && !s_tvalid);
        repeat (20) @(posedge aclk);
        hold_sender = 1'b0;

        // random: prefixes drawn from a small pool so matches happen
        for (int i = 0; i < 8; i++) begin
            base_hi[i] = rand64();
            base_lo[i] = rand64();
        end
        for (int n = 0; n < 350; n++) begin
            k = $urandom_range(7);
            r = $urandom_range(99);
            plen = $urandom_range(140);
            if (r < 3) plen = 255;
            if (n == 120) begin
                wait (pending_items.size() == 0);
                quiet_drive = 1'b1;
            end
            if (n == 180) begin
                wait (pending_items.size() == 0);
                quiet_drive = 1'b0;
            end
            if (r < 45)
                add_item(OP_UPDATE, base_hi[k] ^ (rand64() >> $urandom_range(64)),
                         base_lo[k] ^ (rand64() >> $urandom_range(64)), 8'(plen),
                         $urandom_range(9) != 0,
                         ($urandom_range(9) == 0) ? 0 :
                         ($urandom_range(19) == 0) ? $urandom() : $urandom_range(6));
            else if (r < 70)
                add_item(OP_LOOKUP, base_hi[k] ^ (rand64() >> $urandom_range(64)),
                         ($urandom_range(1)) ? base_lo[k] : rand64(), 8'(plen), 0, 0);
            else if (r < 95)
                add_item(OP_TICK, rand64(), rand64(), 8'(plen), 1'($urandom_range(1)),
                         $urandom());
            else
                add_item(op_t'($urandom_range(3)), rand64(), rand64(), 8'(plen),
                         1'($urandom_range(1)), $urandom());
        end

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_rsps.size() == 0);
        repeat (50) @(posedge aclk);
        if (expected_rsps.size() != 0) mismatches++;
        $display("covered about 390 items: updates, lookups, ticks, full table, expiries");
        $display("%0d results checked, %0d tick expiries, %0d mismatches",
                 rsp_count, expire_count, mismatches);
        if (mismatches == 0) begin
            $display("PASS ipv6_onlink_prefix_table");
        end else begin
            $display("FAIL ipv6_onlink_prefix_table");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAIL ipv6_onlink_prefix_table");
        $finish;
    end

endmodule
